// File: src/mrrp_pkg.sv
// Package for the multi-reader ring producer: widths, codes and shared types.
// No dependencies; every module of the block imports it.
package mrrp_pkg;

  localparam int SLOTS    = 8;
  localparam int SLOT_W   = 3;
  localparam int CNT_W    = 4;
  localparam int CAP_W    = 22;
  localparam int POS_W    = 32;
  localparam int DIV_STEPS = 32;

  // Request codes.
  localparam logic [1:0] FN_WRITE  = 2'd0;
  localparam logic [1:0] FN_SUB    = 2'd1;
  localparam logic [1:0] FN_UNSUB  = 2'd2;
  localparam logic [1:0] FN_CURSOR = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_STREAM = 2'd1;
  localparam logic [1:0] ST_SIZE   = 2'd2;
  localparam logic [1:0] ST_REJECT = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_STREAM_ID = 2'd0;
  localparam logic [1:0] REG_CAPACITY  = 2'd1;
  localparam logic [1:0] REG_ENABLE    = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = 22'd3968;
  localparam logic [CAP_W-1:0] CAP_MIN   = 22'd8;

  // Handshake between the sequencer and the remainder unit.
  typedef struct packed {
    logic             go;
    logic [POS_W-1:0] dividend;
    logic [CAP_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CAP_W-1:0] rem;
  } div_rsp_t;

endpackage

// File: src/mrrp_rem.sv
// Restoring remainder unit: one quotient bit per cycle.
// Depends on mrrp_pkg.
module mrrp_rem (
  input  logic               clk,
  input  logic               rst,
  input  mrrp_pkg::div_req_t req,
  output mrrp_pkg::div_rsp_t rsp
);
  import mrrp_pkg::*;

  logic [POS_W-1:0] shreg;
  logic [CAP_W:0]   part;
  logic [CAP_W-1:0] dvs;
  logic [5:0]       cnt;
  logic             run;
  logic             done_q;
  logic [CAP_W+1:0] trial;
  logic [CAP_W+1:0] shifted;

  // One shift-and-subtract step.
  always_comb begin
    shifted = {part, shreg[POS_W-1]};
    trial   = shifted - {2'b00, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run    <= 1'b0;
      done_q <= 1'b0;
      cnt    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req.go) begin
        run   <= 1'b1;
        shreg <= req.dividend;
        dvs   <= req.divisor;
        part  <= '0;
        cnt   <= 6'(DIV_STEPS);
      end else if (run) begin
        shreg <= {shreg[POS_W-2:0], 1'b0};
        if (!trial[CAP_W+1]) part <= trial[CAP_W:0];
        else part <= shifted[CAP_W:0];
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run    <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The partial remainder holds the final value once the last step is done.
  assign rsp = '{done: done_q, rem: part[CAP_W-1:0]};

  // The remainder must stay below the divisor.
  always_ff @(posedge clk) begin
    if (!rst && rsp.done) assert (rsp.rem < dvs) else $error("remainder not reduced");
  end
endmodule

// File: src/multi_reader_ring_producer.sv
// Top level of the multi-reader ring producer: configuration, reader tables,
// and the sequencer that walks the slots. Depends on mrrp_pkg and mrrp_rem.
//
// One request is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with done high, and the receiver cannot stall
// it. A rejected request, a subscribe, an unsubscribe and a cursor update go
// from the accepting edge through the S_DONE state to their result. A write
// first runs a 32-step remainder unit for the ring offset. With subscribers
// the sequencer walks one slot per cycle below the subscriber count to find
// the slowest reader, then checks the room; if readers must be pushed it
// walks the slots once more. No new request is taken until the result is
// shown. Busy drops in the result cycle.
module multi_reader_ring_producer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [21:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [15:0] target_stream,
  input  logic [15:0] length,
  input  logic [15:0] entry_tag,
  input  logic [31:0] requester,
  input  logic [7:0]  slot,
  input  logic [31:0] new_cursor,
  output logic        done,
  output logic [1:0]  status,
  output logic [15:0] accepted_length,
  output logic [21:0] entry_offset,
  output logic        wrap_marker,
  output logic [21:0] wrap_offset,
  output logic [31:0] producer_position,
  output logic [2:0]  assigned_slot,
  output logic        readers_dropped
);
  import mrrp_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_PLACE, S_MIN, S_PUSH, S_DONE} state_t;

  state_t            state;
  logic [15:0]       own_id;
  logic [CAP_W-1:0]  cap_reg;
  logic              enabled;
  logic [POS_W-1:0]  producer_index;
  logic [CNT_W-1:0]  sub_count;
  logic [POS_W-1:0]  reader_pid [SLOTS];
  logic [POS_W-1:0]  reader_cursor [SLOTS];

  logic [15:0]       len_q;
  logic [CAP_W-1:0]  cap;
  logic [CAP_W:0]    elen;
  logic [POS_W-1:0]  p;
  logic [POS_W-1:0]  mincur;
  logic [POS_W-1:0]  adv;
  logic [SLOT_W-1:0] idx;
  logic [CAP_W-1:0]  off;

  div_req_t dreq;
  div_rsp_t drsp;
  logic     div_go;

  logic [POS_W-1:0]  used;
  logic [POS_W-1:0]  avail;
  logic              walk_last;
  logic              slot_live;
  logic [CAP_W:0]    elen_in;
  logic [CAP_W-1:0]  cap_in;
  logic [SLOT_W-1:0] sl;
  logic              slot_ok;

  mrrp_rem u_rem (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // Request decode helpers.
  always_comb begin
    cap_in  = (cap_reg < CAP_MIN) ? CAP_MIN : cap_reg;
    elen_in = 23'(({7'd0, length} + 23'd11) & ~23'd7);
    sl      = slot[SLOT_W-1:0];
    slot_ok = (slot < 8'(SLOTS)) && (reader_pid[sl] == requester) && (requester != '0);
    walk_last = ({1'b0, idx} == 4'(sub_count - 4'd1)) || (idx == SLOT_W'(SLOTS - 1));
    slot_live = ({1'b0, idx} < sub_count) && (reader_pid[idx] != '0);
    used  = p - mincur;
    if (used > {10'd0, cap}) used = {10'd0, cap};
    avail = {10'd0, cap} - used;
  end

  assign busy = (state != S_IDLE);
  assign dreq = '{go: div_go, dividend: producer_index, divisor: cap};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      own_id    <= '0;
      cap_reg   <= CAP_RESET;
      enabled   <= 1'b0;
      producer_index <= '0;
      sub_count <= '0;
      done      <= 1'b0;
      div_go    <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        reader_pid[i]    <= '0;
        reader_cursor[i] <= '0;
      end
    end else begin
      done   <= 1'b0;
      div_go <= 1'b0;
      // Configuration writes.
      if (cfg_we) begin
        case (cfg_index)
          REG_STREAM_ID: own_id <= cfg_data[15:0];
          REG_CAPACITY:  cap_reg <= cfg_data;
          REG_ENABLE: begin
            enabled <= cfg_data[0];
            if (cfg_data[0]) begin
              producer_index <= '0;
              sub_count <= '0;
              for (int i = 0; i < SLOTS; i++) begin
                reader_pid[i]    <= '0;
                reader_cursor[i] <= '0;
              end
            end
          end
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            status <= ST_OK; accepted_length <= '0; entry_offset <= '0;
            wrap_marker <= 1'b0; wrap_offset <= '0; producer_position <= '0;
            assigned_slot <= '0; readers_dropped <= 1'b0;
            len_q <= length; cap <= cap_in; elen <= elen_in;
            state <= S_DONE;
            if (!enabled || target_stream != own_id) begin
              status <= ST_STREAM;
            end else begin
              case (func)
                FN_WRITE: begin
                  if (length == '0 || elen_in > {1'b0, cap_in}) status <= ST_SIZE;
                  else begin
                    div_go <= 1'b1;
                    state  <= S_DIV;
                  end
                end
                FN_SUB: begin
                  if (requester == '0 || sub_count >= 4'(SLOTS)) status <= ST_REJECT;
                  else begin
                    reader_pid[sub_count[SLOT_W-1:0]]    <= requester;
                    reader_cursor[sub_count[SLOT_W-1:0]] <= producer_index;
                    assigned_slot     <= sub_count[SLOT_W-1:0];
                    producer_position <= producer_index;
                    sub_count <= sub_count + 4'd1;
                  end
                end
                FN_UNSUB: begin
                  if (!slot_ok) status <= ST_REJECT;
                  else begin
                    reader_pid[sl]    <= '0;
                    reader_cursor[sl] <= '0;
                    if (sub_count != '0) sub_count <= sub_count - 4'd1;
                  end
                end
                FN_CURSOR: begin
                  if (!slot_ok) status <= ST_REJECT;
                  else reader_cursor[sl] <= new_cursor;
                end
                default: ;
              endcase
            end
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            off   <= drsp.rem;
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          // Wrap when the entry would run past the end of the ring.
          if ({1'b0, off} + elen > {1'b0, cap}) begin
            wrap_marker  <= 1'b1;
            wrap_offset  <= off;
            p            <= producer_index + 32'(cap - off);
            mincur       <= producer_index + 32'(cap - off);
            entry_offset <= '0;
          end else begin
            p            <= producer_index;
            mincur       <= producer_index;
            entry_offset <= off;
          end
          idx <= '0;
          if (sub_count != '0) state <= S_MIN;
          else state <= S_DONE;
          if (sub_count == '0) begin
            producer_index    <= producer_index + 32'(elen) +
                                 (({1'b0, off} + elen > {1'b0, cap}) ? 32'(cap - off) : '0);
            producer_position <= producer_index + 32'(elen) +
                                 (({1'b0, off} + elen > {1'b0, cap}) ? 32'(cap - off) : '0);
            accepted_length   <= len_q;
          end
        end
        S_MIN: begin
          // One slot per cycle toward the slowest reader.
          if (slot_live && (idx == '0 || reader_cursor[idx] < mincur))
            mincur <= reader_cursor[idx];
          if (walk_last) begin
            idx   <= '0;
            state <= S_PUSH;
            adv   <= '0;
          end else idx <= idx + 1'b1;
        end
        S_PUSH: begin
          if (idx == '0 && adv == '0) begin
            if (avail < 32'(elen)) adv <= 32'(elen) - avail;
            else begin
              producer_index    <= p + 32'(elen);
              producer_position <= p + 32'(elen);
              accepted_length   <= len_q;
              state <= S_DONE;
            end
          end else begin
            // One slot per cycle: push a reader that would be overrun.
            if (slot_live && ((p - reader_cursor[idx]) + adv) > {10'd0, cap}) begin
              reader_cursor[idx] <= reader_cursor[idx] + adv;
              readers_dropped    <= 1'b1;
            end
            if (walk_last) begin
              producer_index    <= p + 32'(elen);
              producer_position <= p + 32'(elen);
              accepted_length   <= len_q;
              state <= S_DONE;
            end else idx <= idx + 1'b1;
          end
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result beat carries the ok status whenever it reports a drop.
  assert property (@(posedge clk) disable iff (rst)
    done && readers_dropped |-> status == ST_OK) else $error("drop on failed request");
  // A subscriber count never exceeds the slot table.
  assert property (@(posedge clk) disable iff (rst)
    sub_count <= 4'(SLOTS)) else $error("subscriber count overflow");
  // A result beat comes while busy is low.
  assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("busy during result beat");
  // Only a write reports a wrap marker, and only with ok status.
  assert property (@(posedge clk) disable iff (rst)
    done && wrap_marker |-> status == ST_OK) else $error("stray wrap marker");
endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the multi-reader ring producer.
// Depends on mrrp_pkg and multi_reader_ring_producer, which uses mrrp_rem.
`timescale 1ns / 1ps

module tb_top;
  import mrrp_pkg::*;

  localparam int SETTLE_CYCLES = 60;

  typedef struct {
    logic [1:0]  fn;
    logic [15:0] sid;
    logic [15:0] len;
    logic [15:0] tag;
    logic [31:0] pid;
    logic [7:0]  slt;
    logic [31:0] cur;
  } request_t;

  typedef struct {
    logic [1:0]  st;
    logic [15:0] acc;
    logic [21:0] eoff;
    logic        wmark;
    logic [21:0] woff;
    logic [31:0] ppos;
    logic [2:0]  aslot;
    logic        dropped;
  } outcome_t;

  // One row of the directed table; a fixed status is checked without the predictor.
  typedef struct {
    request_t   rq;
    bit         fixed;
    logic [1:0] st;
  } row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [21:0] cfg_data;
  logic        start;
  logic        busy;
  logic [1:0]  func;
  logic [15:0] target_stream;
  logic [15:0] length;
  logic [15:0] entry_tag;
  logic [31:0] requester;
  logic [7:0]  slot;
  logic [31:0] new_cursor;
  logic        done;
  logic [1:0]  status;
  logic [15:0] accepted_length;
  logic [21:0] entry_offset;
  logic        wrap_marker;
  logic [21:0] wrap_offset;
  logic [31:0] producer_position;
  logic [2:0]  assigned_slot;
  logic        readers_dropped;

  // Shadow of the configuration and the ring state.
  logic [15:0] own_sid;
  logic [21:0] ring_cap;
  logic        enabled;
  logic [31:0] prod_idx;
  int unsigned sub_count;
  logic [31:0] pid_tab[SLOTS];
  logic [31:0] cursor_tab[SLOTS];

  outcome_t pending_results[$];
  row_t     dir_rows[$];
  int       errors;
  int       n_beats;
  int       n_results;
  int       n_wraps;
  int       n_drops;
  int       burst_left;

  multi_reader_ring_producer i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start(start), .busy(busy), .func(func), .target_stream(target_stream),
    .length(length),
    .entry_tag(entry_tag), .requester(requester), .slot(slot), .new_cursor(new_cursor),
    .done(done), .status(status), .accepted_length(accepted_length),
    .entry_offset(entry_offset), .wrap_marker(wrap_marker), .wrap_offset(wrap_offset),
    .producer_position(producer_position), .assigned_slot(assigned_slot),
    .readers_dropped(readers_dropped)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] eff_cap();
    return (ring_cap < 22'd8) ? 32'd8 : {10'd0, ring_cap};
  endfunction

  function automatic void clear_ring();
    prod_idx  = '0;
    sub_count = 0;
    for (int i = 0; i < SLOTS; i++) begin
      pid_tab[i]    = '0;
      cursor_tab[i] = '0;
    end
  endfunction

  // Slowest active reader; a live slot 0 sets the minimum whatever its cursor.
  function automatic logic [31:0] slowest_cursor(logic [31:0] pos);
    logic [31:0] m;
    m = pos;
    for (int i = 0; i < SLOTS && i < sub_count; i++) begin
      if (pid_tab[i] != 0 && (i == 0 || cursor_tab[i] < m)) m = cursor_tab[i];
    end
    return m;
  endfunction

  // Works out the result of one accepted beat and updates the shadow state.
  function automatic outcome_t ring_outcome(request_t r);
    outcome_t    o;
    logic [31:0] cap, elen, p, off, used, avail, adv, lag;
    o = '{default: '0};
    cap  = eff_cap();
    elen = (32'd4 + {16'd0, r.len} + 32'd7) & ~32'd7;
    if (!enabled || r.sid != own_sid) begin
      o.st = ST_STREAM;
    end else if (r.fn == FN_WRITE) begin
      if (r.len == 0 || elen > cap) begin
        o.st = ST_SIZE;
      end else begin
        p   = prod_idx;
        off = p % cap;
        if (off + elen > cap) begin
          o.wmark = 1'b1;
          o.woff  = off[21:0];
          p       = p + (cap - off);
          off     = '0;
        end
        if (sub_count > 0) begin
          used = p - slowest_cursor(p);
          if (used > cap) used = cap;
          avail = cap - used;
          if (avail < elen) begin
            adv = elen - avail;
            for (int i = 0; i < SLOTS && i < sub_count; i++) begin
              lag = (p - cursor_tab[i]) + adv;
              if (pid_tab[i] != 0 && lag > cap) begin
                cursor_tab[i] = cursor_tab[i] + adv;
                o.dropped     = 1'b1;
              end
            end
          end
        end
        prod_idx = p + elen;
        o.acc    = r.len;
        o.eoff   = off[21:0];
        o.ppos   = prod_idx;
      end
    end else if (r.fn == FN_SUB) begin
      if (r.pid == 0 || sub_count >= SLOTS) begin
        o.st = ST_REJECT;
      end else begin
        pid_tab[sub_count]    = r.pid;
        cursor_tab[sub_count] = prod_idx;
        o.aslot               = sub_count[2:0];
        o.ppos                = prod_idx;
        sub_count++;
      end
    end else if (r.pid == 0 || r.slt >= SLOTS || pid_tab[r.slt] != r.pid) begin
      o.st = ST_REJECT;
    end else if (r.fn == FN_UNSUB) begin
      pid_tab[r.slt]    = '0;
      cursor_tab[r.slt] = '0;
      if (sub_count > 0) sub_count--;
    end else begin
      cursor_tab[r.slt] = r.cur;
    end
    return o;
  endfunction

  // Random request; most name this stream and an owned slot so the state goes deep.
  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    int unsigned len_hi;
    logic [31:0] c;
    c      = eff_cap();
    len_hi = (c > 200) ? 200 : ((c > 4) ? c - 4 : 1);
    pick   = $urandom_range(0, 99);
    r.fn   = (pick < 50) ? FN_WRITE : (pick < 65) ? FN_SUB : (pick < 75) ? FN_UNSUB : FN_CURSOR;
    r.sid  = ($urandom_range(0, 19) == 0) ? 16'($urandom) : own_sid;
    pick   = $urandom_range(0, 19);
    r.len  = (pick == 0) ? 16'd0 : (pick == 1) ? 16'($urandom) : 16'($urandom_range(1, len_hi));
    r.tag  = 16'($urandom);
    r.slt  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, SLOTS - 1));
    pick   = $urandom_range(0, 9);
    if (r.fn != FN_SUB && pick < 7 && r.slt < SLOTS) r.pid = pid_tab[r.slt];
    else if (pick == 9) r.pid = $urandom;
    else r.pid = 32'($urandom_range(0, 6));
    if ($urandom_range(0, 4) == 0) r.cur = $urandom;
    else r.cur = prod_idx - 32'($urandom_range(0, 2 * c));
    return r;
  endfunction

  task automatic cfg_write(logic [1:0] idx, logic [21:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_STREAM_ID: own_sid  = val[15:0];
      REG_CAPACITY:  ring_cap = val;
      REG_ENABLE: begin
        enabled = val[0];
        if (val[0]) clear_ring();
      end
      default: ;
    endcase
  endtask

  // Lets every expected beat come back, then idles with start low.
  task automatic drain();
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Drives one beat from a falling edge until it is taken, then goes on in a burst or idles at random.
  task automatic send_beat(request_t r, bit fixed, logic [1:0] fixed_st);
    outcome_t o;
    func          = r.fn;
    target_stream = r.sid;
    length        = r.len;
    entry_tag     = r.tag;
    requester     = r.pid;
    slot          = r.slt;
    new_cursor    = r.cur;
    start         = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    if (fixed) begin
      o    = '{default: '0};
      o.st = fixed_st;
    end else begin
      o = ring_outcome(r);
    end
    pending_results.push_back(o);
    n_beats++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // Result checker: every done beat is matched against the oldest expectation.
  always @(posedge clk) begin
    outcome_t w;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no request outstanding");
        errors++;
      end else begin
        w = pending_results.pop_front();
        n_results++;
        if (wrap_marker === 1'b1) n_wraps++;
        if (readers_dropped === 1'b1) n_drops++;
        check_field("status", w.st, status);
        check_field("accepted_length", w.acc, accepted_length);
        check_field("entry_offset", w.eoff, entry_offset);
        check_field("wrap_marker", w.wmark, wrap_marker);
        check_field("wrap_offset", w.woff, wrap_offset);
        check_field("producer_position", w.ppos, producer_position);
        check_field("assigned_slot", w.aslot, assigned_slot);
        check_field("readers_dropped", w.dropped, readers_dropped);
      end
    end
  end

  // Run limit.
  initial begin
    #40ms;
    $display("FAIL");
    $finish;
  end

  // Stimulus.
  initial begin
    logic [15:0] S;
    request_t    w8;
    logic [21:0] phase_caps[10];
    logic [15:0] phase_sid;
    errors = 0; n_beats = 0; n_results = 0; n_wraps = 0; n_drops = 0; burst_left = 0;
    rst = 1'b1; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0; start = 1'b0;
    func = '0; target_stream = '0; length = '0; entry_tag = '0; requester = '0;
    slot = '0; new_cursor = '0;
    own_sid = '0; ring_cap = CAP_RESET; enabled = 1'b0;
    clear_ring();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: the stream does not exist yet after reset.
    S  = 16'h1234;
    w8 = '{fn: FN_WRITE, sid: 16'h0, len: 16'd8, tag: 16'h0, pid: 32'h0, slt: 8'h0, cur: 32'h0};
    send_beat(w8, 1'b1, ST_STREAM);
    drain();
    cfg_write(REG_STREAM_ID, 22'(S));
    cfg_write(REG_CAPACITY, 22'd64);
    cfg_write(REG_ENABLE, 22'd1);

    dir_rows.push_back('{'{FN_WRITE, S, 16'd0, 16'hFFFF, 32'h0, 8'h0, 32'h0}, 1, ST_SIZE});
    dir_rows.push_back('{'{FN_WRITE, S, 16'hFFFF, 16'h0, 32'h0, 8'h0, 32'h0}, 1, ST_SIZE});
    dir_rows.push_back('{'{FN_WRITE, S, 16'd61, 16'h0, 32'h0, 8'h0, 32'h0}, 1, ST_SIZE});
    dir_rows.push_back('{'{FN_WRITE, S, 16'd60, 16'h0, 32'h0, 8'h0, 32'h0}, 0, ST_OK});
    dir_rows.push_back('{'{FN_WRITE, 16'hFFFF, 16'd8, 16'h0, 32'h0, 8'h0, 32'h0}, 1, ST_STREAM});
    dir_rows.push_back('{'{FN_SUB, S, 16'd0, 16'h0, 32'h0, 8'h0, 32'h0}, 1, ST_REJECT});
    dir_rows.push_back('{'{FN_SUB, S, 16'd0, 16'h0, 32'hFFFF_FFFF, 8'h0, 32'h0}, 0, ST_OK});
    dir_rows.push_back('{'{FN_SUB, S, 16'd0, 16'h0, 32'd7, 8'h0, 32'h0}, 0, ST_OK});
    dir_rows.push_back('{'{FN_CURSOR, S, 16'd0, 16'h0, 32'd7, 8'd9, 32'h0}, 1, ST_REJECT});
    dir_rows.push_back('{'{FN_CURSOR, S, 16'd0, 16'h0, 32'd8, 8'd1, 32'h0}, 1, ST_REJECT});
    dir_rows.push_back('{'{FN_CURSOR, S, 16'd0, 16'h0, 32'd7, 8'hFF, 32'h0}, 1, ST_REJECT});
    dir_rows.push_back('{'{FN_WRITE, S, 16'd20, 16'h0, 32'h0, 8'h0, 32'h0}, 0, ST_OK});
    dir_rows.push_back('{'{FN_WRITE, S, 16'd20, 16'h0, 32'h0, 8'h0, 32'h0}, 0, ST_OK});
    dir_rows.push_back('{'{FN_WRITE, S, 16'd1, 16'h0, 32'h0, 8'h0, 32'h0}, 0, ST_OK});
    dir_rows.push_back('{'{FN_CURSOR, S, 16'd0, 16'h0, 32'd7, 8'd1, 32'hFFFF_FFFF}, 0, ST_OK});
    dir_rows.push_back('{'{FN_WRITE, S, 16'd40, 16'h0, 32'h0, 8'h0, 32'h0}, 0, ST_OK});
    dir_rows.push_back('{'{FN_UNSUB, S, 16'd0, 16'h0, 32'hFFFF_FFFF, 8'd0, 32'h0}, 0, ST_OK});
    dir_rows.push_back('{'{FN_UNSUB, S, 16'd0, 16'h0, 32'hFFFF_FFFF, 8'd0, 32'h0}, 1, ST_REJECT});
    // A subscribe after an unsubscribe reuses the slot at the count, over a live reader.
    for (int i = 0; i < 7; i++)
      dir_rows.push_back('{'{FN_SUB, S, 16'd0, 16'h0, 32'(100 + i), 8'h0, 32'h0}, 0, ST_OK});
    dir_rows.push_back('{'{FN_SUB, S, 16'd0, 16'h0, 32'd200, 8'h0, 32'h0}, 1, ST_REJECT});
    dir_rows.push_back('{'{FN_WRITE, S, 16'd8, 16'h0, 32'h0, 8'h0, 32'h0}, 0, ST_OK});
    foreach (dir_rows[i]) send_beat(dir_rows[i].rq, dir_rows[i].fixed, dir_rows[i].st);

    // Random part, one phase per ring setting; a zero capacity acts as the minimum.
    phase_caps = '{22'd0, 22'd8, 22'd9, 22'd64, 22'd100, 22'd4096, 22'd3968,
                   22'h3FFFFF, 22'd1000, 22'd300};
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      phase_sid = (ph == 0) ? 16'h0 : (ph == 1) ? 16'hFFFF : 16'($urandom);
      cfg_write(REG_STREAM_ID, 22'(phase_sid));
      cfg_write(REG_CAPACITY, phase_caps[ph]);
      cfg_write(REG_ENABLE, (ph == 8) ? 22'd0 : 22'd1);
      for (int k = 0; k < 160; k++) send_beat(random_request(), 1'b0, ST_OK);
    end

    drain();
    $display("Ran %0d request beats over ten ring settings: %0d results checked,", n_beats,
             n_results);
    $display("%0d with a wrap marker and %0d with readers dropped.", n_wraps, n_drops);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/mrrp_pkg.sv
src/mrrp_rem.sv
src/multi_reader_ring_producer.sv
tb/tb_top.sv
